// ----- rtl/b64e_pkg.sv -----
// b64e_pkg: shared types, constants and the alphabet lookup for the base64 encoder.
// No dependencies.
`default_nettype none
package b64e_pkg;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // pending byte count in the front
  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_TWO   = 2'd2;

  // bytes carried by a group
  localparam logic [1:0] GRP_ONE  = 2'd1;
  localparam logic [1:0] GRP_TWO  = 2'd2;
  localparam logic [1:0] GRP_FULL = 2'd3;

  localparam logic [1:0] IDX_LAST = 2'd3;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       fin;
  } b64e_grp_t;

  function automatic logic [7:0] b64e_char(input logic [5:0] s);
    logic [7:0] v;
    v = {2'b00, s};
    if (s < 6'd26)      return v + 8'd65;         // 'A'
    else if (s < 6'd52) return v + 8'd71;         // 'a' - 26
    else if (s < 6'd62) return v - 8'd4;          // '0' - 52
    else if (s == 6'd62) return 8'h2B;            // '+'
    else                return 8'h2F;             // '/'
  endfunction

endpackage
`default_nettype wire

// ----- rtl/b64e_if.sv -----
// b64e_in_if / b64e_out_if: valid/ready channels for input bytes and output characters.
// No dependencies.
`default_nettype none
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       final_char;
  modport source (output valid, output out_char, output final_char, input ready);
  modport sink   (input valid, input out_char, input final_char, output ready);
endinterface
`default_nettype wire

// ----- rtl/b64e_fifo.sv -----
// b64e_fifo: short group queue between front and back.
// Depends on b64e_pkg.
`default_nettype none
module b64e_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire b64e_pkg::b64e_grp_t wr_data,
  output logic                    full,
  input  wire logic               pop,
  output b64e_pkg::b64e_grp_t     rd_data,
  output logic                    empty
);
  import b64e_pkg::*;

  b64e_grp_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign full    = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/b64e_front.sv -----
// b64e_front: takes input bytes, holds pending bytes, forms groups for the queue.
// Depends on b64e_pkg and b64e_in_if.
`default_nettype none
module b64e_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  b64e_in_if.sink             in_ch,
  output logic                push,
  output b64e_pkg::b64e_grp_t grp,
  input  wire logic           full
);
  import b64e_pkg::*;

  logic [7:0] held_first_r, held_first_nxt;
  logic [7:0] held_second_r, held_second_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       acc;

  assign in_ch.ready = !full;
  assign acc         = in_ch.valid && !full;

  always_comb begin
    held_first_nxt  = held_first_r;
    held_second_nxt = held_second_r;
    fill_nxt        = fill_r;
    push            = 1'b0;
    grp.b0          = held_first_r;
    grp.b1          = held_second_r;
    grp.b2          = in_ch.data_byte;
    grp.nbytes      = GRP_FULL;
    grp.fin         = in_ch.final_byte;
    case (fill_r)
      FILL_EMPTY: begin
        grp.b0     = in_ch.data_byte;
        grp.b1     = 8'd0;
        grp.b2     = 8'd0;
        grp.nbytes = GRP_ONE;
      end
      FILL_ONE: begin
        grp.b1     = in_ch.data_byte;
        grp.b2     = 8'd0;
        grp.nbytes = GRP_TWO;
      end
      default: ;  // two pending (three never arises)
    endcase
    if (acc) begin
      if (!in_ch.final_byte && fill_r == FILL_EMPTY) begin
        held_first_nxt = in_ch.data_byte;
        fill_nxt       = FILL_ONE;
      end else if (!in_ch.final_byte && fill_r == FILL_ONE) begin
        held_second_nxt = in_ch.data_byte;
        fill_nxt        = FILL_TWO;
      end else begin
        push     = 1'b1;
        fill_nxt = FILL_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= FILL_EMPTY;
      held_first_r  <= 8'd0;
      held_second_r <= 8'd0;
    end else begin
      fill_r        <= fill_nxt;
      held_first_r  <= held_first_nxt;
      held_second_r <= held_second_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/b64e_back.sv -----
// b64e_back: pops groups and sends four characters each through the output register.
// Depends on b64e_pkg and b64e_out_if.
`default_nettype none
module b64e_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire b64e_pkg::b64e_grp_t  head,
  input  wire logic                 empty,
  output logic                      pop,
  b64e_out_if.source                out_ch
);
  import b64e_pkg::*;

  b64e_grp_t  cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_final_r, out_final_nxt;
  logic       load, emit;
  logic [5:0] sext;
  logic       is_pad;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_char   = out_char_r;
  assign out_ch.final_char = out_final_r;

  assign load = !out_valid_r || out_ch.ready;
  assign emit = load && cur_valid_r;
  assign pop  = !empty && (!cur_valid_r || (emit && idx_r == IDX_LAST));

  always_comb begin
    case (idx_r)
      2'd0:    sext = cur_r.b0[7:2];
      2'd1:    sext = {cur_r.b0[1:0], cur_r.b1[7:4]};
      2'd2:    sext = {cur_r.b1[3:0], cur_r.b2[7:6]};
      default: sext = cur_r.b2[5:0];
    endcase
    case (idx_r)
      2'd2:    is_pad = (cur_r.nbytes == GRP_ONE);
      2'd3:    is_pad = (cur_r.nbytes != GRP_FULL);
      default: is_pad = 1'b0;
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_final_nxt = out_final_r;
    if (load) begin
      out_valid_nxt = cur_valid_r;
    end
    if (emit) begin
      out_char_nxt  = is_pad ? PAD_CHAR : b64e_char(sext);
      out_final_nxt = (idx_r == IDX_LAST) && cur_r.fin;
      idx_nxt       = idx_r + 2'd1;
      if (idx_r == IDX_LAST) begin
        cur_valid_nxt = 1'b0;
      end
    end
    if (pop) begin
      cur_nxt       = head;
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    out_char_r  <= out_char_nxt;
    out_final_r <= out_final_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/base64_stream_encoder_top.sv -----
// Base64 stream encoder: the byte closing a group goes into the queue, then into the current-group
// register, then its first character into the output register; one character per cycle out while
// the receiver is ready, a rate set by the four characters each group needs. Bytes that only fill the group are held.
// Queue of two groups decouples input from output; input stalls only while it is full.
// Reset: synchronous, active low; clears fill count, held bytes, queue and output valid.
`default_nettype none
module base64_stream_encoder_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  b64e_in_if.sink    in_ch,
  b64e_out_if.source out_ch
);
  import b64e_pkg::*;

  b64e_grp_t push_grp, head_grp;
  logic      push, pop, full, empty;

  b64e_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .push  (push),
    .grp   (push_grp),
    .full  (full)
  );

  b64e_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_grp),
    .full    (full),
    .pop     (pop),
    .rd_data (head_grp),
    .empty   (empty)
  );

  b64e_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head_grp),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/b64e_checker.sv -----
// b64e_props: port-level assertions for the base64 encoder, bound to the top level.
// Depends on base64_stream_encoder_top ports.
`default_nettype none
module b64e_props (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       final_char
);
  localparam logic [7:0] PAD = 8'h3D;

  logic pend_pad_r;

  // a non-final pad is always followed by the final pad
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_pad_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      pend_pad_r <= (out_char == PAD) && !final_char;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(final_char))
    else $error("stalled output word changed");

  a_pad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    pend_pad_r && out_valid |-> out_char == PAD && final_char)
    else $error("first pad not followed by final pad");

endmodule

bind base64_stream_encoder_top b64e_props u_b64e_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_char   (out_ch.out_char),
  .final_char (out_ch.final_char)
);
`default_nettype wire

// ----- verif/b64e_checker.sv -----
// b64e_checker: watches the byte and character channels of the base64 encoder,
// predicts the characters each accepted byte causes and compares them in order.
// Depends on nothing but the channel signals wired in by the testbench top.
module b64e_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       out_final_char,
  output int         fail_count,
  output int         chars_pending
);

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [7:0] PAD = 8'h3D;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  enc_char_t  expected_chars[$];
  logic [7:0] held_first;
  logic [7:0] held_second;
  logic [1:0] group_fill;

  assign chars_pending = expected_chars.size();

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return ALPHABET[8*(63 - s) +: 8];
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic last);
    enc_char_t c;
    c.ch   = ch;
    c.last = last;
    expected_chars.push_back(c);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [1:0] fill;
    fill = (group_fill == 2'd3) ? 2'd2 : group_fill;
    if (!fin && fill == 2'd0) begin
      held_first = b;
      group_fill = 2'd1;
    end else if (!fin && fill == 2'd1) begin
      held_second = b;
      group_fill  = 2'd2;
    end else begin
      group_fill = 2'd0;
      case (fill)
        2'd2: begin
          push_char(sextet_char(held_first[7:2]), 1'b0);
          push_char(sextet_char({held_first[1:0], held_second[7:4]}), 1'b0);
          push_char(sextet_char({held_second[3:0], b[7:6]}), 1'b0);
          push_char(sextet_char(b[5:0]), fin);
        end
        2'd0: begin
          push_char(sextet_char(b[7:2]), 1'b0);
          push_char(sextet_char({b[1:0], 4'h0}), 1'b0);
          push_char(PAD, 1'b0);
          push_char(PAD, 1'b1);
        end
        default: begin
          push_char(sextet_char(held_first[7:2]), 1'b0);
          push_char(sextet_char({held_first[1:0], b[7:4]}), 1'b0);
          push_char(sextet_char({b[3:0], 2'b00}), 1'b0);
          push_char(PAD, 1'b1);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    enc_char_t want;
    if (!rst_n) begin
      held_first  = 8'h00;
      held_second = 8'h00;
      group_fill  = 2'd0;
      expected_chars.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected char: out_char %h final_char %b", out_char, out_final_char);
          fail_count = fail_count + 1;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %h actual %h", want.ch, out_char);
            fail_count = fail_count + 1;
          end
          if (out_final_char !== want.last) begin
            $error("final_char: expected %b actual %b", want.last, out_final_char);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        encode_byte(in_data_byte, in_final_byte);
    end
  end

  initial fail_count = 0;

endmodule

// ----- verif/tb_base64_stream_encoder_top.sv -----
// tb_base64_stream_encoder_top: drives byte messages into the base64 encoder with random
// sender gaps and receiver stalls; b64e_checker does prediction and comparison.
// Depends on b64e_if.sv, base64_stream_encoder_top.sv and b64e_checker.sv.
module tb_base64_stream_encoder_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BYTES_PER_PHASE = 50;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycles;
  int   fail_count;
  int   chars_pending;
  int   bytes_sent;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_stream_encoder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b64e_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_data_byte   (in_ch.data_byte),
    .in_final_byte  (in_ch.final_byte),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_char       (out_ch.out_char),
    .out_final_char (out_ch.final_char),
    .fail_count     (fail_count),
    .chars_pending  (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("base64_stream_encoder_top test failed");
      $finish;
    end
  end

  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic push_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic random_message();
    int         len;
    logic [7:0] b;
    len = ($urandom_range(9) < 8) ? $urandom_range(1, 9) : $urandom_range(10, 24);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      push_byte(b, i == len - 1);
    end
  endtask

  initial begin
    cycles           = 0;
    bytes_sent       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single byte, both pads
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // two bytes, one pad
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // full groups, no pad
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // group then two-byte tail
    push_byte(8'hFB, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b1);
    // length six
    for (int i = 1; i <= 6; i++)
      push_byte(i[7:0], i == 6);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < BYTES_PER_PHASE) random_message();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && chars_pending == 0)
      $display("base64_stream_encoder_top test passed");
    else
      $display("base64_stream_encoder_top test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_fifo.sv
rtl/b64e_front.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_top.sv
rtl/b64e_checker.sv
verif/b64e_checker.sv
verif/tb_base64_stream_encoder_top.sv
